// File: hdl/smtb_pkg.sv
// Shared types and codes for the bit-banged touch controller SPI master.
package smtb_pkg;

   // Widths fixed by the channel payloads.
   localparam int OP_W    = 2;
   localparam int VALUE_W = 8;
   localparam int WORD_W  = 16;

   // Operation codes carried on the request channel.
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_SET_CS = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   // Transfer modes.
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // Half-period phases inside one bit.
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   // One request item.
   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [VALUE_W-1:0] value;
      logic               miso_level;
   } req_type;

   // One response item.
   typedef struct packed {
      logic              sck_level;
      logic              mosi_level;
      logic              cs_level;
      logic [WORD_W-1:0] read_word;
      logic              done_res;
      logic              busy_res;
      logic              rejected;
   } rsp_type;

endpackage

// File: hdl/smtb_chan_if.sv
// Valid/ready channel interface that carries one payload struct per transfer.
interface smtb_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/spi_master_touch_bitbang_core.sv
// Bit-banged SPI master for a touch controller, one half-period tick per request.
//
// Requests arrive on req (valid/ready); each is a tick, a chip-select set, a
// byte write or a word read. Every accepted request yields exactly one
// response on rsp with the SCK, MOSI and CS levels after that request, the
// received word on the tick that ends a read, and done, busy and rejected flags.
// A write takes 2*WRITE_BITS+1 ticks after its command, a read 3*READ_BITS.
// Commands issued while a transfer runs are rejected and change nothing.
// A request is registered at the input, and the response register is loaded from
// it by the state update logic. Throughput is one request per cycle while rsp
// does not stall; the only loop is the update of the mode, phase, bit counter,
// shift registers and pin registers.
// When rsp stalls, the response and one pending request are held and req
// deasserts ready; no transfer is lost or repeated. Reset is synchronous:
// it empties both registers, idles the engine, drives SCK and MOSI low and
// CS high (deselected).
module spi_master_touch_bitbang_core #(
   parameter int WRITE_BITS = 8,
   parameter int READ_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   smtb_chan_if.sink   req,
   smtb_chan_if.source rsp
);
   import smtb_pkg::*;

   localparam int MAX_BITS = (WRITE_BITS > READ_BITS) ? WRITE_BITS : READ_BITS;
   localparam int CNT_W    = $clog2(MAX_BITS + 1);
   localparam logic [CNT_W-1:0] WRITE_LAST = CNT_W'(WRITE_BITS);
   localparam logic [CNT_W-1:0] READ_LAST  = CNT_W'(READ_BITS);

   // Input stage registers.
   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff;

   // Output stage registers.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Transfer engine state.
   logic [1:0]            mode_ff, mode_in;
   logic [1:0]            phase_ff, phase_in;
   logic [CNT_W-1:0]      bits_ff, bits_in;
   logic [WRITE_BITS-1:0] send_ff, send_in;
   logic [WORD_W-1:0]     recv_ff, recv_in;
   logic                  sck_ff, sck_in;
   logic                  mosi_ff, mosi_in;
   logic                  cs_ff, cs_in;

   logic                        advance;
   logic [WORD_W+VALUE_W-1:0]   value_wide;
   logic [WRITE_BITS-1:0]       value_ext;
   logic [CNT_W-1:0]            bits_inc;
   logic [WORD_W-1:0]           word;
   logic                        done;
   logic                        rej;

   // Handshake: the input stage moves on when the output register is free or
   // being emptied in this cycle.
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready    = !req_valid_ff || advance;
   assign req_valid_in = req.valid || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp.ready);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.payload  = rsp_data_ff;

   // Write data fitted to the shift register width; bits above the byte are zero.
   assign value_wide = {{WORD_W{1'b0}}, req_data_ff.value};
   assign value_ext  = value_wide[WRITE_BITS-1:0];
   assign bits_inc   = bits_ff + 1'b1;

   // Next engine state from the registered request.
   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      bits_in  = bits_ff;
      send_in  = send_ff;
      recv_in  = recv_ff;
      sck_in   = sck_ff;
      mosi_in  = mosi_ff;
      cs_in    = cs_ff;
      word     = '0;
      done     = 1'b0;
      rej      = 1'b0;
      if (req_data_ff.operation != OP_TICK) begin
         if (mode_ff != MODE_IDLE) begin
            rej = 1'b1;
         end else begin
            case (req_data_ff.operation)
               OP_SET_CS: begin
                  cs_in = req_data_ff.value[0];
               end
               OP_WRITE: begin
                  mode_in  = MODE_WRITE;
                  phase_in = PHASE_FIRST;
                  bits_in  = '0;
                  mosi_in  = value_ext[WRITE_BITS-1];
                  send_in  = value_ext << 1;
                  sck_in   = 1'b0;
               end
               OP_READ: begin
                  mode_in  = MODE_READ;
                  phase_in = PHASE_FIRST;
                  bits_in  = '0;
                  recv_in  = '0;
                  sck_in   = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end else begin
         case (mode_ff)
            MODE_WRITE: begin
               case (phase_ff)
                  PHASE_FIRST: begin
                     sck_in   = 1'b1;
                     phase_in = PHASE_SECOND;
                  end
                  PHASE_SECOND: begin
                     bits_in = bits_inc;
                     sck_in  = 1'b0;
                     if (bits_inc < WRITE_LAST) begin
                        mosi_in  = send_ff[WRITE_BITS-1];
                        send_in  = send_ff << 1;
                        phase_in = PHASE_FIRST;
                     end else begin
                        phase_in = PHASE_THIRD;
                     end
                  end
                  default: begin
                     done     = 1'b1;
                     mode_in  = MODE_IDLE;
                     phase_in = PHASE_FIRST;
                  end
               endcase
            end
            MODE_READ: begin
               case (phase_ff)
                  PHASE_FIRST: begin
                     sck_in   = 1'b0;
                     phase_in = PHASE_SECOND;
                  end
                  PHASE_SECOND: begin
                     recv_in  = {recv_ff[WORD_W-2:0], req_data_ff.miso_level};
                     sck_in   = 1'b1;
                     phase_in = PHASE_THIRD;
                  end
                  default: begin
                     bits_in  = bits_inc;
                     phase_in = PHASE_FIRST;
                     if (bits_inc >= READ_LAST) begin
                        done    = 1'b1;
                        word    = recv_ff;
                        mode_in = MODE_IDLE;
                     end
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // Response built from the updated pin levels.
   always_comb begin
      rsp_data_in.sck_level  = sck_in;
      rsp_data_in.mosi_level = mosi_in;
      rsp_data_in.cs_level   = cs_in;
      rsp_data_in.read_word  = word;
      rsp_data_in.done_res   = done;
      rsp_data_in.busy_res   = (mode_in != MODE_IDLE);
      rsp_data_in.rejected   = rej;
   end

   // Control and engine registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         phase_ff     <= PHASE_FIRST;
         bits_ff      <= '0;
         send_ff      <= '0;
         recv_ff      <= '0;
         sck_ff       <= 1'b0;
         mosi_ff      <= 1'b0;
         cs_ff        <= 1'b1;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff  <= mode_in;
            phase_ff <= phase_in;
            bits_ff  <= bits_in;
            send_ff  <= send_in;
            recv_ff  <= recv_in;
            sck_ff   <= sck_in;
            mosi_ff  <= mosi_in;
            cs_ff    <= cs_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req.ready) begin
         req_data_ff <= req.payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the bit-banged touch controller SPI master.
`timescale 1ns / 100ps

module tb_top;
   import smtb_pkg::*;

   localparam int WR_BITS     = 8;
   localparam int RD_BITS     = 16;
   localparam int SEND_MSB    = (WR_BITS - 1) % 16;
   localparam int ITEM_TARGET = 1650;
   localparam int STALL_LIMIT = 5000;
   localparam int SQUEEZE_AT  = 300;
   localparam int SQUEEZE_LEN = 300;

   // How the MISO pin behaves across the ticks of one sequence.
   typedef enum int {MISO_LOW, MISO_HIGH, MISO_RANDOM} miso_pattern_e;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Testbench-side drivers; all inputs are known from time zero.
   logic    req_valid = 1'b0;
   req_type req_item  = '0;
   logic    rsp_ready = 1'b0;

   smtb_chan_if #(.payload_type(req_type)) req_ch ();
   smtb_chan_if #(.payload_type(rsp_type)) rsp_ch ();

   assign req_ch.valid   = req_valid;
   assign req_ch.payload = req_item;
   assign rsp_ch.ready   = rsp_ready;

   spi_master_touch_bitbang_core #(
      .WRITE_BITS (WR_BITS),
      .READ_BITS  (RD_BITS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #1 clock = ~clock;

   // Commands waiting to be sent and pin states waiting to be seen.
   req_type cmd_queue[$];
   rsp_type expected_pins[$];

   int mismatch_count = 0;
   int reqs_accepted  = 0;
   int rsps_accepted  = 0;
   int idle_run       = 0;
   int total_items    = 0;
   bit req_taken      = 1'b0;
   bit rsp_taken      = 1'b0;

   // Idle pacing for both sides.
   int tx_wait = 0;
   int tx_run  = 0;
   int rx_wait = 0;
   int rx_run  = 0;
   int rx_hold = 0;
   bit squeeze_done = 1'b0;

   // Predicted engine state.
   logic [1:0]        mode_q;
   logic [1:0]        phase_q;
   logic [4:0]        nbits_q;
   logic [15:0]       send_sr;
   logic [WORD_W-1:0] recv_sr;
   logic              sck_q;
   logic              mosi_q;
   logic              cs_q;

   // Advance the predicted engine by one command and return the pin levels after it.
   function automatic rsp_type bitbang_step(input req_type cmd);
      rsp_type           pins;
      logic [WORD_W-1:0] word;
      logic              finished;
      logic              refused;
      word     = '0;
      finished = 1'b0;
      refused  = 1'b0;
      if (cmd.operation != OP_TICK) begin
         if (mode_q != MODE_IDLE) begin
            refused = 1'b1;
         end else if (cmd.operation == OP_SET_CS) begin
            cs_q = cmd.value[0];
         end else if (cmd.operation == OP_WRITE) begin
            mode_q  = MODE_WRITE;
            phase_q = PHASE_FIRST;
            nbits_q = '0;
            send_sr = {8'h00, cmd.value};
            mosi_q  = send_sr[SEND_MSB];
            send_sr = send_sr << 1;
            sck_q   = 1'b0;
         end else begin
            mode_q  = MODE_READ;
            phase_q = PHASE_FIRST;
            nbits_q = '0;
            recv_sr = '0;
            sck_q   = 1'b1;
         end
      end else if (mode_q == MODE_WRITE) begin
         // Write: data with SCK low, then SCK high, and one closing low half period.
         case (phase_q)
            PHASE_FIRST: begin
               sck_q   = 1'b1;
               phase_q = PHASE_SECOND;
            end
            PHASE_SECOND: begin
               nbits_q = nbits_q + 1'b1;
               sck_q   = 1'b0;
               if (nbits_q < WR_BITS) begin
                  mosi_q  = send_sr[SEND_MSB];
                  send_sr = send_sr << 1;
                  phase_q = PHASE_FIRST;
               end else begin
                  phase_q = PHASE_THIRD;
               end
            end
            default: begin
               finished = 1'b1;
               mode_q   = MODE_IDLE;
               phase_q  = PHASE_FIRST;
            end
         endcase
      end else if (mode_q == MODE_READ) begin
         // Read: high, low, high; MISO is taken as the low phase ends.
         case (phase_q)
            PHASE_FIRST: begin
               sck_q   = 1'b0;
               phase_q = PHASE_SECOND;
            end
            PHASE_SECOND: begin
               recv_sr = {recv_sr[WORD_W-2:0], cmd.miso_level};
               sck_q   = 1'b1;
               phase_q = PHASE_THIRD;
            end
            default: begin
               nbits_q = nbits_q + 1'b1;
               phase_q = PHASE_FIRST;
               if (nbits_q >= RD_BITS) begin
                  finished = 1'b1;
                  word     = recv_sr;
                  mode_q   = MODE_IDLE;
               end
            end
         endcase
      end
      pins.sck_level  = sck_q;
      pins.mosi_level = mosi_q;
      pins.cs_level   = cs_q;
      pins.read_word  = word;
      pins.done_res   = finished;
      pins.busy_res   = (mode_q != MODE_IDLE);
      pins.rejected   = refused;
      return pins;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("response %0d %s got 0x%0h expected 0x%0h",
                                   rsps_accepted, name, got, want));
      end
   endtask

   task automatic queue_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                             input logic miso);
      req_type cmd;
      cmd.operation  = op;
      cmd.value      = val;
      cmd.miso_level = miso;
      cmd_queue.push_back(cmd);
   endtask

   // Queue a run of ticks, now and then with a stray command that must be refused.
   task automatic queue_ticks(input int count, input miso_pattern_e pattern);
      logic miso;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            queue_item(OP_W'($urandom_range(OP_SET_CS, OP_READ)), VALUE_W'($urandom),
                       1'($urandom));
         end
         case (pattern)
            MISO_LOW:  miso = 1'b0;
            MISO_HIGH: miso = 1'b1;
            default:   miso = 1'($urandom);
         endcase
         queue_item(OP_TICK, VALUE_W'($urandom), miso);
      end
   endtask

   // Build the whole command list: a directed opening, then random sequences.
   task automatic build_stimulus();
      int            kind;
      int            ticks;
      logic [7:0]    data;
      miso_pattern_e pattern;
      // Idle tick, chip select at both levels, and a write that refuses commands.
      queue_item(OP_TICK, 8'hFF, 1'b1);
      queue_item(OP_SET_CS, 8'h00, 1'b0);
      queue_item(OP_SET_CS, 8'hFF, 1'b1);
      queue_item(OP_SET_CS, 8'hFE, 1'b0);
      queue_item(OP_WRITE, 8'hA5, 1'b0);
      queue_item(OP_READ, 8'h00, 1'b1);
      queue_item(OP_SET_CS, 8'h01, 1'b0);
      queue_item(OP_WRITE, 8'h00, 1'b1);
      for (int i = 0; i < 2 * WR_BITS + 1; i++) begin
         queue_item(OP_TICK, 8'h00, i[0]);
      end
      while (cmd_queue.size() < ITEM_TARGET) begin
         kind = $urandom_range(0, 19);
         if (kind < 4) begin
            queue_item(OP_SET_CS, VALUE_W'($urandom), 1'($urandom));
         end else if (kind < 11) begin
            case ($urandom_range(0, 5))
               0:       data = 8'h00;
               1:       data = 8'hFF;
               default: data = 8'($urandom);
            endcase
            queue_item(OP_WRITE, data, 1'($urandom));
            ticks = 2 * WR_BITS + 1;
            // An occasional write is cut short so that the next command lands busy.
            if ($urandom_range(0, 9) == 0) begin
               ticks = $urandom_range(0, ticks - 1);
            end
            queue_ticks(ticks, MISO_RANDOM);
         end else if (kind < 17) begin
            queue_item(OP_READ, VALUE_W'($urandom), 1'($urandom));
            ticks = 3 * RD_BITS;
            if ($urandom_range(0, 9) == 0) begin
               ticks = $urandom_range(0, ticks - 1);
            end
            case ($urandom_range(0, 3))
               0:       pattern = MISO_LOW;
               1:       pattern = MISO_HIGH;
               default: pattern = MISO_RANDOM;
            endcase
            queue_ticks(ticks, pattern);
         end else if (kind == 17) begin
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
               queue_item(OP_W'($urandom_range(OP_TICK, OP_READ)), VALUE_W'($urandom),
                          1'($urandom));
            end
         end else begin
            for (int i = $urandom_range(1, 3); i > 0; i--) begin
               queue_item(OP_TICK, VALUE_W'($urandom), 1'($urandom));
            end
         end
      end
   endtask

   // Sample both channels, predict on each request transfer, check each response.
   always @(posedge clock) begin
      if (reset) begin
         mode_q    = MODE_IDLE;
         phase_q   = PHASE_FIRST;
         nbits_q   = '0;
         send_sr   = '0;
         recv_sr   = '0;
         sck_q     = 1'b0;
         mosi_q    = 1'b0;
         cs_q      = 1'b1;
         req_taken = 1'b0;
         rsp_taken = 1'b0;
         idle_run  = 0;
      end else begin
         req_taken = req_ch.valid && req_ch.ready;
         rsp_taken = rsp_ch.valid && rsp_ch.ready;
         if (req_taken) begin
            expected_pins.push_back(bitbang_step(req_ch.payload));
            reqs_accepted++;
         end
         if (rsp_taken) begin
            if (expected_pins.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with nothing expected",
                                         rsps_accepted));
            end else begin
               rsp_type got;
               rsp_type want;
               got  = rsp_ch.payload;
               want = expected_pins.pop_front();
               check_field("sck_level", int'(got.sck_level), int'(want.sck_level));
               check_field("mosi_level", int'(got.mosi_level), int'(want.mosi_level));
               check_field("cs_level", int'(got.cs_level), int'(want.cs_level));
               check_field("read_word", int'(got.read_word), int'(want.read_word));
               check_field("done_res", int'(got.done_res), int'(want.done_res));
               check_field("busy_res", int'(got.busy_res), int'(want.busy_res));
               check_field("rejected", int'(got.rejected), int'(want.rejected));
            end
            rsps_accepted++;
         end
         idle_run = (req_taken || rsp_taken) ? 0 : idle_run + 1;
      end
   end

   // Request driver: hold each command until its transfer, then idle for a drawn gap.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_taken) begin
            if (tx_run > 0) begin
               tx_run--;
               tx_wait = 0;
            end else if ($urandom_range(0, 15) == 0) begin
               tx_run  = $urandom_range(10, 40);
               tx_wait = 0;
            end else begin
               tx_wait = $urandom_range(0, 19);
            end
         end
         if (tx_wait > 0) begin
            tx_wait--;
            req_valid <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            req_item  <= cmd_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response sink: random stalls, plus one long hold-off that backs up the block.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if (rx_run > 0) begin
               rx_run--;
               rx_wait = 0;
            end else if ($urandom_range(0, 15) == 0) begin
               rx_run  = $urandom_range(10, 40);
               rx_wait = 0;
            end else begin
               rx_wait = $urandom_range(0, 19);
            end
            if (!squeeze_done && rsps_accepted >= SQUEEZE_AT) begin
               squeeze_done = 1'b1;
               rx_hold      = SQUEEZE_LEN;
            end
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: too long without any transfer ends the run.
   initial begin
      while (idle_run < STALL_LIMIT) begin
         @(posedge clock);
      end
      $display("== FAIL ==");
      $finish;
   end

   // Main sequence: build stimulus, release reset, drain, and give the verdict.
   initial begin
      build_stimulus();
      total_items = cmd_queue.size();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      while (reqs_accepted < total_items || expected_pins.size() != 0) begin
         @(negedge clock);
      end
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_pins.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
